/* hw/rtl/qwst_pkg.sv */
// Shared types, codes and the node combine function for the queue wait tree.
package qwst_pkg;

  localparam int NODE_W = 32;
  localparam int SLOT_W = 11;
  localparam int DUR_W  = 20;
  localparam int WAIT_W = 30;

  localparam logic [NODE_W-1:0] NODE_MAX = 32'hFFFF_FFFF;
  localparam logic [NODE_W-1:0] WAIT_MAX = 32'h3FFF_FFFF;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] sum;
    logic [NODE_W-1:0] finish;
  } node_t;

  function automatic logic [NODE_W-1:0] sat_add(input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b);
    logic [NODE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[NODE_W] ? NODE_MAX : s[NODE_W-1:0];
  endfunction

  // left range a followed by right range b
  function automatic node_t node_join(input node_t a, input node_t b);
    node_t             res;
    logic [NODE_W-1:0] lf;
    res.sum    = sat_add(a.sum, b.sum);
    lf         = sat_add(a.finish, b.sum);
    res.finish = (lf > b.finish) ? lf : b.finish;
    return res;
  endfunction

endpackage

/* hw/rtl/queue_wait_segment_tree_core.sv */
// Top level: segment tree of service durations with wait queries.
// Nodes live in two single-port-write memories, even-numbered nodes in one and odd-numbered
// in the other, each read at its own address through a registered output, so the two children of
// a node come out of one read and the two boundary nodes of a prefix query come out together.
// An update writes its leaf and then recomputes each ancestor in a read state (S_RD) followed
// by a combine/write state (S_PULL). A query walks up to log2(SLOTS)+1 levels, each in a read
// state and a join state, then a finish state and an output state; the output state waits while
// an earlier result still waits in the output register. Updates to slot zero or beyond SLOTS
// are dropped. After reset an initialization pass writes every leaf and rebuilds every inner
// node, during which in_ready stays low. One request is in flight at a time; a finished result
// waits in the output register while the next request is taken.
module queue_wait_segment_tree_core
  import qwst_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [SLOT_W-1:0] slot,
  input  logic [DUR_W-1:0]  duration,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAIT_W-1:0] wait_time
);

  localparam int AW = $clog2(SLOTS);
  localparam int IW = AW + 2;
  localparam logic [IW-1:0] BASE = IW'(SLOTS);
  localparam logic [IW-1:0] TOP  = IW'(2 * SLOTS);
  localparam logic [IW-1:0] ROOT = IW'(1);

  typedef enum logic [3:0] {
    S_CLR_LEAF,
    S_IDLE,
    S_UPD_LEAF,
    S_RD,
    S_PULL,
    S_Q_RD,
    S_Q_JOIN,
    S_Q_FIN,
    S_Q_OUT
  } state_t;

  state_t            state;
  logic              clearing;
  logic [IW-1:0]     p;
  logic [IW-1:0]     l;
  logic [IW-1:0]     r;
  logic              l_hit;
  logic              r_hit;
  node_t             left;
  node_t             right;
  logic              left_v;
  logic              right_v;
  logic [NODE_W-1:0] all_f;
  logic              all_v;
  logic [SLOT_W-1:0] req_slot;
  logic [DUR_W-1:0]  req_dur;

  node_t mem_even [SLOTS];
  node_t mem_odd  [SLOTS];
  node_t rd_even;
  node_t rd_odd;

  logic          we;
  logic          wsel;
  logic [AW-1:0] wa;
  node_t         wd;
  logic [AW-1:0] ra_even;
  logic [AW-1:0] ra_odd;

  node_t             pull_node;
  node_t             left_next;
  node_t             right_next;
  node_t             all_node;
  logic [NODE_W-1:0] diff;
  logic [WAIT_W-1:0] wait_next;
  logic              slot_over;

  assign in_ready  = (state == S_IDLE);
  assign slot_over = 32'(slot) > 32'(SLOTS);

  assign pull_node  = node_join(rd_even, rd_odd);
  assign left_next  = left_v ? node_join(left, rd_odd) : rd_odd;
  assign right_next = right_v ? node_join(rd_even, right) : rd_even;
  assign all_node   = node_join(left, right);

  always_comb begin
    diff      = all_f - 32'(req_slot);
    wait_next = '0;
    if (all_v && (all_f > 32'(req_slot))) begin
      wait_next = (diff > WAIT_MAX) ? WAIT_MAX[WAIT_W-1:0] : diff[WAIT_W-1:0];
    end
  end

  always_comb begin
    we      = 1'b0;
    wsel    = p[0];
    wa      = p[AW:1];
    wd      = '0;
    ra_even = p[AW-1:0];
    ra_odd  = p[AW-1:0];
    case (state)
      S_CLR_LEAF: begin
        we        = 1'b1;
        wd.sum    = '0;
        wd.finish = 32'(p - BASE) + 32'd1;
      end
      S_UPD_LEAF: begin
        we        = 1'b1;
        wd.sum    = 32'(req_dur);
        wd.finish = 32'(req_dur) + 32'(req_slot);
      end
      S_PULL: begin
        we = 1'b1;
        wd = pull_node;
      end
      S_Q_RD: begin
        ra_odd  = l[AW:1];
        ra_even = r[AW:1];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      if (wsel) begin
        mem_odd[wa] <= wd;
      end else begin
        mem_even[wa] <= wd;
      end
    end
    rd_even <= mem_even[ra_even];
    rd_odd  <= mem_odd[ra_odd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_LEAF;
      clearing  <= 1'b1;
      p         <= BASE;
      out_valid <= 1'b0;
    end else begin
      // S_Q_OUT either reloads the result register or keeps it held
      if (out_valid && out_ready && state != S_Q_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR_LEAF: begin
          if (p == TOP - ROOT) begin
            p     <= BASE - ROOT;
            state <= S_RD;
          end else begin
            p <= p + ROOT;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_slot <= slot;
            req_dur  <= duration;
            if (operation == OP_QUERY) begin
              l       <= BASE;
              r       <= slot_over ? TOP : BASE + IW'(slot);
              left_v  <= 1'b0;
              right_v <= 1'b0;
              state   <= S_Q_RD;
            end else if (slot != '0 && !slot_over) begin
              p     <= BASE + IW'(slot) - ROOT;
              state <= S_UPD_LEAF;
            end
          end
        end
        S_UPD_LEAF: begin
          p     <= p >> 1;
          state <= S_RD;
        end
        S_RD: begin
          state <= S_PULL;
        end
        S_PULL: begin
          if (p == ROOT) begin
            clearing <= 1'b0;
            state    <= S_IDLE;
          end else begin
            p     <= clearing ? p - ROOT : p >> 1;
            state <= S_RD;
          end
        end
        S_Q_RD: begin
          if (l < r) begin
            l_hit <= l[0];
            r_hit <= r[0];
            l     <= (l + IW'(l[0])) >> 1;
            r     <= r >> 1;
            state <= S_Q_JOIN;
          end else begin
            state <= S_Q_FIN;
          end
        end
        S_Q_JOIN: begin
          if (l_hit) begin
            left   <= left_next;
            left_v <= 1'b1;
          end
          if (r_hit) begin
            right   <= right_next;
            right_v <= 1'b1;
          end
          state <= S_Q_RD;
        end
        S_Q_FIN: begin
          all_v <= left_v || right_v;
          if (left_v && right_v) begin
            all_f <= all_node.finish;
          end else if (left_v) begin
            all_f <= left.finish;
          end else begin
            all_f <= right.finish;
          end
          state <= S_Q_OUT;
        end
        S_Q_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            wait_time <= wait_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/qwst_checker.sv */
// Port-level checks for the queue wait tree, bound to the top level.
module qwst_checker
  import qwst_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WAIT_W-1:0] wait_time
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wait_time))
    else $error("result changed while stalled");

  // reset starts the init pass: nothing taken, nothing shown
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("block ready or showing a result right after reset");

  // an update never makes a result appear
  a_set_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_SET && !out_valid |=> !out_valid)
    else $error("result appeared after an update request");

  // a query leaves the block not ready in the cycle after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_QUERY |=> !in_ready)
    else $error("request taken right after a query");

endmodule

bind queue_wait_segment_tree_core qwst_checker u_qwst_checker (.*);

/* verif/queue_wait_checker.sv */
// Scoreboard for the queue wait tree: mirrors the node store, predicts each wait and checks it.
module queue_wait_checker
  import qwst_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              operation,
  input  logic [SLOT_W-1:0] slot,
  input  logic [DUR_W-1:0]  duration,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [WAIT_W-1:0] wait_time,
  output int                errors,
  output int                pending
);

  typedef struct {
    logic [NODE_W-1:0] total;
    logic [NODE_W-1:0] done;
    bit                any;
  } span_t;

  logic [NODE_W-1:0] span_total [2*SLOTS];
  logic [NODE_W-1:0] span_done  [2*SLOTS];
  logic [WAIT_W-1:0] wait_due [$];
  logic [WAIT_W-1:0] due;

  function automatic logic [NODE_W-1:0] clip_add(input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b);
    logic [NODE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[NODE_W] ? {NODE_W{1'b1}} : s[NODE_W-1:0];
  endfunction

  // a covers the earlier slots, b the later ones
  function automatic span_t chain(input span_t a, input span_t b);
    span_t             r;
    logic [NODE_W-1:0] carried;
    if (!a.any) return b;
    if (!b.any) return a;
    r.total = clip_add(a.total, b.total);
    carried = clip_add(a.done, b.total);
    r.done  = (carried > b.done) ? carried : b.done;
    r.any   = 1'b1;
    return r;
  endfunction

  function automatic span_t node_span(input int i);
    span_t r;
    r.total = span_total[i];
    r.done  = span_done[i];
    r.any   = 1'b1;
    return r;
  endfunction

  function automatic void refresh(input int i);
    span_t r;
    r = chain(node_span(2*i), node_span(2*i + 1));
    span_total[i] = r.total;
    span_done[i]  = r.done;
  endfunction

  function automatic void clear_tree();
    span_total[0] = '0;
    span_done[0]  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      span_total[SLOTS + i] = '0;
      span_done[SLOTS + i]  = NODE_W'(i + 1);
    end
    for (int i = SLOTS - 1; i >= 1; i--) refresh(i);
  endfunction

  function automatic void set_duration(input logic [SLOT_W-1:0] s, input logic [DUR_W-1:0] d);
    int p;
    if (s == 0 || s > SLOTS) return;
    p = SLOTS + int'(s) - 1;
    span_total[p] = NODE_W'(d);
    span_done[p]  = clip_add(NODE_W'(d), NODE_W'(s));
    for (p = p >> 1; p >= 1; p = p >> 1) refresh(p);
  endfunction

  function automatic logic [WAIT_W-1:0] predict_wait(input logic [SLOT_W-1:0] t);
    span_t  lo;
    span_t  hi;
    span_t  all;
    int     l;
    int     r;
    longint w;
    lo.total = '0;
    lo.done  = '0;
    lo.any   = 1'b0;
    hi = lo;
    l = SLOTS;
    if (t > SLOTS) r = 2*SLOTS;
    else r = SLOTS + int'(t);
    while (l < r) begin
      if (l[0]) begin
        lo = chain(lo, node_span(l));
        l++;
      end
      if (r[0]) begin
        r--;
        hi = chain(node_span(r), hi);
      end
      l = l >> 1;
      r = r >> 1;
    end
    all = chain(lo, hi);
    w = 0;
    if (all.any && all.done > t) w = longint'(all.done) - longint'(t);
    if (w > longint'(WAIT_MAX)) w = longint'(WAIT_MAX);
    return w[WAIT_W-1:0];
  endfunction

  // result side first: a result leaving at this edge belongs to an earlier query
  always @(posedge clk) begin
    if (rst) begin
      clear_tree();
      wait_due.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (wait_due.size() == 0) begin
          errors++;
          $error("wait_time: result with no query pending, actual %0d", wait_time);
        end else begin
          due = wait_due.pop_front();
          if (wait_time !== due) begin
            errors++;
            $error("wait_time: expected %0d, actual %0d", due, wait_time);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (operation == OP_QUERY) wait_due.push_back(predict_wait(slot));
        else set_duration(slot, duration);
      end
      pending = wait_due.size();
    end
  end

endmodule

/* verif/queue_wait_segment_tree_core_tb.sv */
// Testbench top for the queue wait tree: clock, reset, request and result traffic, verdict.
module queue_wait_segment_tree_core_tb;
  import qwst_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int SLOT_TOP     = (1 << SLOT_W) - 1;
  localparam int DUR_TOP      = (1 << DUR_W) - 1;
  localparam int LIMIT_CYCLES = 600000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [SLOT_W-1:0] slot;
  logic [DUR_W-1:0]  duration;
  logic              out_valid;
  logic              out_ready;
  logic [WAIT_W-1:0] wait_time;
  int                errors;
  int                pending;
  bit                calm;
  bit                hold_req;

  queue_wait_segment_tree_core #(.SLOTS(SLOTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .slot      (slot),
    .duration  (duration),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wait_time (wait_time)
  );

  queue_wait_checker #(.SLOTS(SLOTS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .slot      (slot),
    .duration  (duration),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wait_time (wait_time),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, plus a long hold-off at each toggle of hold_req
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else
        out_ready = calm || ($urandom_range(99) >= 27);
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic op, input int s, input int d);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    slot      = SLOT_W'(s);
    duration  = DUR_W'(d);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
  endtask

  function automatic int pick_slot();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 9) return $urandom_range(SLOT_TOP, SLOTS + 1);
    if (r < 13) return SLOTS;
    if (r < 17) return 1;
    if (r < 50) return $urandom_range(32, 1);
    return $urandom_range(SLOTS, 1);
  endfunction

  function automatic int pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return DUR_TOP;
    if (r < 50) return $urandom_range(63);
    return $urandom_range(DUR_TOP);
  endfunction

  initial begin
    logic op;
    int   t;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = OP_SET;
    slot      = '0;
    duration  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // fresh tree, time zero, beyond the last slot, dropped updates
    send(OP_QUERY, 0, DUR_TOP);
    send(OP_QUERY, 1, 0);
    send(OP_QUERY, SLOTS, 0);
    send(OP_QUERY, SLOT_TOP, 20'h5A5A5);
    send(OP_SET, 0, DUR_TOP);
    send(OP_SET, SLOTS + 1, DUR_TOP);
    send(OP_SET, SLOT_TOP, 1);
    send(OP_QUERY, SLOT_TOP, 0);
    send(OP_SET, 1, DUR_TOP);
    send(OP_QUERY, 0, 0);
    send(OP_QUERY, 1, 0);
    send(OP_QUERY, 2, 0);
    send(OP_SET, SLOTS, DUR_TOP);
    send(OP_SET, SLOTS / 2, 1);
    send(OP_QUERY, SLOTS / 2, 0);
    send(OP_QUERY, SLOTS - 1, 0);
    send(OP_QUERY, SLOTS, 0);
    send(OP_QUERY, SLOTS + 1, 0);
    send(OP_SET, 1, 0);
    send(OP_QUERY, SLOTS, 0);
    send(OP_SET, SLOTS, 0);
    send(OP_QUERY, SLOT_TOP, DUR_TOP);
    pause_until_drained();

    // mixed traffic
    for (int i = 0; i < 520; i++) begin
      if (i == 100) calm = 1'b1;
      if (i == 300) calm = 1'b0;
      if (i == 400) hold_req = ~hold_req;
      op = ($urandom_range(99) < 45) ? OP_QUERY : OP_SET;
      send(op, pick_slot(), pick_duration());
    end
    pause_until_drained();

    // load every slot with a long duration to push the waits toward the top bits
    for (int s = 1; s <= SLOTS; s++) begin
      if (s == 500) hold_req = ~hold_req;
      send(OP_SET, s, ($urandom_range(9) == 0) ? DUR_TOP : $urandom_range(DUR_TOP, 20'hC0000));
      if ($urandom_range(7) == 0) begin
        t = ($urandom_range(99) < 15) ? $urandom_range(SLOT_TOP, SLOTS + 1)
                                       : $urandom_range(s, 0);
        send(OP_QUERY, t, $urandom_range(DUR_TOP));
      end
    end
    pause_until_drained();

    // removals among queries
    for (int i = 0; i < 160; i++) begin
      if ($urandom_range(1) == 1)
        send(OP_QUERY, pick_slot(), $urandom_range(DUR_TOP));
      else
        send(OP_SET, pick_slot(), ($urandom_range(9) < 7) ? 0 : pick_duration());
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
